// ----- hdl/rmfb_pkg.sv -----
// ============================================================================
// rmfb_pkg : shared types and codes for the rotated mono framebuffer engine
// Operation codes, segment codes, beat layout and controller/datapath structs.
// ============================================================================
`default_nettype none

package rmfb_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_FILL    = 2'd0;
  localparam logic [1:0] OP_OUTLINE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // rectangle segments; a fill uses only the first one, at full height
  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_BOTTOM = 2'd1;
  localparam logic [1:0] SEG_LEFT   = 2'd2;
  localparam logic [1:0] SEG_RIGHT  = 2'd3;

  // field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 11;
  localparam int IDX_W   = 14;
  localparam int BYTE_W  = 8;
  // room for a coordinate plus a span without overflow
  localparam int CLIP_W  = COORD_W + 2;

  // input beat layout, lowest bit first
  localparam int IN_X_LSB     = 0;
  localparam int IN_Y_LSB     = IN_X_LSB + COORD_W;
  localparam int IN_W_LSB     = IN_Y_LSB + COORD_W;
  localparam int IN_H_LSB     = IN_W_LSB + COORD_W;
  localparam int IN_COLOR_LSB = IN_H_LSB + COORD_W;
  localparam int IN_IDX_LSB   = IN_COLOR_LSB + 1;
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 8;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       seg_load;
    logic [1:0] seg_sel;
    logic       pix_rd;
    logic       pix_wr;
    logic       sweep_wr;
    logic       byte_rd;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       seg_empty;
    logic       last_pix;
    logic       sweep_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/rotated_mono_framebuffer_rect_engine.sv -----
// ============================================================================
// rotated_mono_framebuffer_rect_engine : 1-bit framebuffer rectangle engine
// Fills, outlines, clears and reads a packed monochrome store addressed in
// landscape coordinates rotated 90 degrees clockwise onto the native panel.
// ============================================================================
//
//  channel | direction | tdata (low bit up)                    | tuser
//  --------+-----------+---------------------------------------+----------------
//  in_     | slave     | pos_x, pos_y, rect_width, rect_height, | operation
//          |           | pixel_color, byte_index, zero pad      |
//  out_    | master    | read_data                              | done_operation
//
//  Each accepted item is dispatched, then: Fill clips one segment at full
//  height and does a read then a write for each pixel left after clipping.
//  Outline does the same over the top, bottom, left and right edge segments, each clipped on its own.
//  Read fetches one byte. Clear sweeps all STORE_BYTES bytes.
//  After reset a sweep writes zero to all STORE_BYTES bytes before the first
//  beat is taken. The result register lets a new beat be taken while a
//  result waits; a stalled result holds the engine only at the end of the
//  next operation.
// ============================================================================
`default_nettype none

module rotated_mono_framebuffer_rect_engine import rmfb_pkg::*; #(
  parameter int NATIVE_WIDTH  = 300,
  parameter int NATIVE_HEIGHT = 400
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // pos_x[10:0], pos_y[21:11], rect_width[32:22], rect_height[43:33],
  // pixel_color[44], byte_index[58:45], zero[63:59]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  wire logic [OP_W-1:0]        in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // read_data[7:0]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // done_operation[1:0]
  output logic [OP_W-1:0]             out_tuser
);

  cmd_t cmd;
  sts_t sts;

  rmfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rmfb_dpath #(
    .NATIVE_WIDTH  (NATIVE_WIDTH),
    .NATIVE_HEIGHT (NATIVE_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

// ----- hdl/rmfb_ctrl.sv -----
// ============================================================================
// rmfb_ctrl : sequencer for the rotated mono framebuffer engine
// Walks each operation through segment setup, pixel read-modify-write,
// store sweeps, byte reads and the output register handshake.
// ============================================================================
`default_nettype none

module rmfb_ctrl import rmfb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_SEG   = 4'd3;
  localparam logic [3:0] ST_PRD   = 4'd4;
  localparam logic [3:0] ST_PWR   = 4'd5;
  localparam logic [3:0] ST_CLEAR = 4'd6;
  localparam logic [3:0] ST_RDB   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       seg_final;

  // a fill is a single segment; an outline has four
  assign seg_final = (sts.op == OP_FILL) || (seg_r == SEG_RIGHT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    cmd       = '0;
    cmd.seg_sel = seg_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISP;
        end
      end
      ST_DISP: begin
        seg_nxt = SEG_TOP;
        unique case (sts.op)
          OP_FILL, OP_OUTLINE: state_nxt = ST_SEG;
          OP_CLEAR:            state_nxt = ST_CLEAR;
          OP_READ:             state_nxt = ST_RDB;
          default:             state_nxt = ST_DONE;
        endcase
      end
      ST_SEG: begin
        cmd.seg_load = 1'b1;
        if (!sts.seg_empty) begin
          state_nxt = ST_PRD;
        end else if (seg_final) begin
          state_nxt = ST_DONE;
        end else begin
          seg_nxt = seg_r + 2'd1;
        end
      end
      ST_PRD: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = ST_PWR;
      end
      ST_PWR: begin
        cmd.pix_wr = 1'b1;
        if (!sts.last_pix) begin
          state_nxt = ST_PRD;
        end else if (seg_final) begin
          state_nxt = ST_DONE;
        end else begin
          seg_nxt   = seg_r + 2'd1;
          state_nxt = ST_SEG;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_DONE;
      end
      ST_RDB: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      seg_r       <= SEG_TOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- hdl/rmfb_dpath.sv -----
// ============================================================================
// rmfb_dpath : datapath of the rotated mono framebuffer engine
// Holds the item, clips rectangle segments, steps pixel coordinates, maps
// them to native byte and bit, and owns the pixel store and result register.
// ============================================================================
`default_nettype none

module rmfb_dpath import rmfb_pkg::*; #(
  parameter int NATIVE_WIDTH  = 300,
  parameter int NATIVE_HEIGHT = 400
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [OP_W-1:0]        in_tuser,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OP_W-1:0]             out_tuser
);

  localparam int ROW_BYTES   = (NATIVE_WIDTH + 3) / 4;
  localparam int ROW_PAIRS   = (NATIVE_HEIGHT + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * ROW_PAIRS;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CX_W        = $clog2(NATIVE_HEIGHT);
  localparam int CY_W        = $clog2(NATIVE_WIDTH);
  localparam int CMP_W       = 18;

  localparam logic [ADDR_W-1:0]        ROW_BYTES_A = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0]        LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);
  localparam logic [CY_W-1:0]          NX_TOP      = CY_W'(NATIVE_WIDTH - 1);
  localparam logic signed [CLIP_W-1:0] X_MAX       = CLIP_W'(NATIVE_HEIGHT - 1);
  localparam logic signed [CLIP_W-1:0] Y_MAX       = CLIP_W'(NATIVE_WIDTH - 1);
  localparam logic signed [CLIP_W-1:0] ONE_S       = CLIP_W'(1);
  localparam logic signed [CLIP_W-1:0] ZERO_S      = '0;

  // input beat fields
  logic signed [COORD_W-1:0] in_x, in_y, in_w, in_h;
  logic                      in_color;
  logic [IDX_W-1:0]          in_idx;

  assign in_x     = $signed(in_tdata[IN_X_LSB +: COORD_W]);
  assign in_y     = $signed(in_tdata[IN_Y_LSB +: COORD_W]);
  assign in_w     = $signed(in_tdata[IN_W_LSB +: COORD_W]);
  assign in_h     = $signed(in_tdata[IN_H_LSB +: COORD_W]);
  assign in_color = in_tdata[IN_COLOR_LSB];
  assign in_idx   = in_tdata[IN_IDX_LSB +: IDX_W];

  // item registers
  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic signed [CLIP_W-1:0]  xw_r, yh_r;
  logic                      dim_ok_r;
  logic                      color_r;
  logic [IDX_W-1:0]          idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r     <= in_tuser;
      x_r      <= in_x;
      y_r      <= in_y;
      xw_r     <= CLIP_W'(in_x) + CLIP_W'(in_w) - ONE_S;
      yh_r     <= CLIP_W'(in_y) + CLIP_W'(in_h) - ONE_S;
      dim_ok_r <= (in_w > 11'sd0) && (in_h > 11'sd0);
      color_r  <= in_color;
      idx_r    <= in_idx;
    end
  end

  // segment corners and clip to the landscape area
  logic signed [CLIP_W-1:0] xs, xe, ys, ye;
  logic signed [CLIP_W-1:0] xlo, xhi, ylo, yhi;
  logic                     seg_empty;

  always_comb begin
    xs = CLIP_W'(x_r);
    xe = xw_r;
    ys = CLIP_W'(y_r);
    ye = yh_r;
    case (cmd.seg_sel)
      SEG_TOP:    if (op_r != OP_FILL) ye = ys;
      SEG_BOTTOM: ys = yh_r;
      SEG_LEFT:   xe = xs;
      SEG_RIGHT:  xs = xw_r;
      default:    ;
    endcase
    xlo = (xs < ZERO_S) ? ZERO_S : xs;
    xhi = (xe > X_MAX)  ? X_MAX  : xe;
    ylo = (ys < ZERO_S) ? ZERO_S : ys;
    yhi = (ye > Y_MAX)  ? Y_MAX  : ye;
    seg_empty = !dim_ok_r || (xlo > xhi) || (ylo > yhi);
  end

  // pixel walk over the clipped segment, row by row
  logic [CX_W-1:0] x0_r, x1_r, cur_x_r;
  logic [CY_W-1:0] y1_r, cur_y_r;
  logic            last_pix;

  assign last_pix = (cur_x_r == x1_r) && (cur_y_r == y1_r);

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      x0_r    <= xlo[CX_W-1:0];
      x1_r    <= xhi[CX_W-1:0];
      y1_r    <= yhi[CY_W-1:0];
      cur_x_r <= xlo[CX_W-1:0];
      cur_y_r <= ylo[CY_W-1:0];
    end else if (cmd.pix_wr) begin
      if (cur_x_r == x1_r) begin
        cur_x_r <= x0_r;
        cur_y_r <= cur_y_r + CY_W'(1);
      end else begin
        cur_x_r <= cur_x_r + CX_W'(1);
      end
    end
  end

  // rotation to native coordinates, then byte address and bit mask
  logic [CY_W-1:0]   nx;
  logic [ADDR_W-1:0] row_pair, col_byte, pix_addr;
  logic [7:0]        pix_mask;

  assign nx       = NX_TOP - cur_y_r;
  assign row_pair = ADDR_W'(cur_x_r >> 1);
  assign col_byte = ADDR_W'(nx >> 2);
  assign pix_addr = row_pair * ROW_BYTES_A + col_byte;
  assign pix_mask = 8'h80 >> {nx[1:0], cur_x_r[0]};

  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        mask_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_rd) begin
      wr_addr_r <= pix_addr;
      mask_r    <= pix_mask;
    end
  end

  // store sweep for reset and clear
  logic [ADDR_W-1:0] sweep_cnt_r;
  logic [7:0]        sweep_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      sweep_val_r <= '0;
    end else if (cmd.load_item) begin
      sweep_cnt_r <= '0;
      sweep_val_r <= {8{in_color}};
    end else if (cmd.sweep_wr) begin
      sweep_cnt_r <= sweep_cnt_r + ADDR_W'(1);
    end
  end

  // read byte range check
  logic idx_ok;
  assign idx_ok = (CMP_W'(idx_r) < CMP_W'(STORE_BYTES));

  // pixel store ports
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rd_data_r;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]        mem_wdata;

  always_comb begin
    mem_re    = cmd.pix_rd || (cmd.byte_rd && idx_ok);
    mem_raddr = cmd.byte_rd ? ADDR_W'(idx_r) : pix_addr;
    mem_we    = cmd.pix_wr || cmd.sweep_wr;
    if (cmd.sweep_wr) begin
      mem_waddr = sweep_cnt_r;
      mem_wdata = sweep_val_r;
    end else begin
      mem_waddr = wr_addr_r;
      mem_wdata = color_r ? (rd_data_r | mask_r) : (rd_data_r & ~mask_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // result register
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OP_W-1:0]        out_op_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (op_r == OP_READ && idx_ok) ? rd_data_r : '0;
      out_op_r   <= op_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_op_r;

  always_comb begin
    sts.op         = op_r;
    sts.seg_empty  = seg_empty;
    sts.last_pix   = last_pix;
    sts.sweep_last = (sweep_cnt_r == LAST_ADDR);
  end

endmodule

`default_nettype wire
